// File: rtl/assert_macros.svh
// assertion macros shared by rfs_front, rfs_queue and rfs_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked at every rising edge of clk, off while rst is high
`define RFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every rising edge of clk, reset included
`define RFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFS_ASSERT(lbl, prop, msg)
`define RFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/rfs_pkg.sv
// shared types and constants of the radio frame sequencer
`timescale 1ns / 1ps
package rfs_pkg;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_CHAR = 2'd1,
    REQ_END  = 2'd2,
    REQ_NONE = 2'd3
  } rfs_req_t;

  // frame kinds on frame_kind
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2,
    KIND_CMD   = 2'd3
  } rfs_kind_t;

  localparam logic [4:0] MAX_PACKET      = 5'd31;
  localparam logic [9:0] ID_ALL_ONES     = 10'd1023;
  localparam logic [9:0] STATION_ID_INIT = 10'd288;
  localparam logic [7:0] TYPE_CMD        = 8'h01;
  localparam logic [7:0] TYPE_START      = 8'h02;
  localparam logic [7:0] TYPE_END        = 8'h03;
  localparam logic [7:0] PAD_BYTE        = 8'h00;

  // register index decoded from paddr
  localparam logic REG_STATION_ID = 1'b0;

  // one classified request: up to three frames, sent start, data, tail
  typedef struct packed {
    logic        start_f;
    logic        data_f;
    logic        tail_f;
    logic        tail_end;   // tail is an end frame, else a command frame
    logic [4:0]  data_num;
    logic [15:0] data_word;
    logic [7:0]  tail_byte;  // packet count or command byte
  } rfs_job_t;

endpackage

// File: rtl/rfs_front.sv
// front end: accepts requests, keeps string state, classifies into jobs
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        char_byte,
  input  logic              q_ready,
  output logic              q_push,
  output rfs_pkg::rfs_job_t q_job
);
  import rfs_pkg::*;

  logic       in_string, in_string_next;
  logic       have_pending, have_pending_next;
  logic [7:0] pending_byte, pending_byte_next;
  logic [4:0] packet_count, packet_count_next;

  logic       accept;
  logic       hp_eff;
  logic [4:0] pc_eff;
  logic [4:0] next_num;
  rfs_job_t   job;

  assign in_stall = !q_ready;
  assign accept   = in_valid && !in_stall;

  // a fresh string starts with an empty pair and count zero
  assign hp_eff   = in_string && have_pending;
  assign pc_eff   = in_string ? packet_count : 5'd0;
  assign next_num = (pc_eff != MAX_PACKET) ? 5'(pc_eff + 5'd1) : 5'd1;

  always_comb begin
    job               = '0;
    in_string_next    = in_string;
    have_pending_next = have_pending;
    pending_byte_next = pending_byte;
    packet_count_next = packet_count;
    unique case (rfs_req_t'(req_type))
      REQ_CMD: begin
        job.tail_f    = 1'b1;
        job.tail_byte = char_byte;
      end
      REQ_CHAR: begin
        job.start_f    = !in_string;
        in_string_next = 1'b1;
        if (hp_eff) begin
          job.data_f        = 1'b1;
          job.data_num      = next_num;
          job.data_word     = {pending_byte, char_byte};
          packet_count_next = next_num;
          have_pending_next = 1'b0;
          pending_byte_next = 8'd0;
        end else begin
          packet_count_next = pc_eff;
          have_pending_next = 1'b1;
          pending_byte_next = char_byte;
        end
      end
      REQ_END: begin
        job.start_f  = !in_string;
        job.tail_f   = 1'b1;
        job.tail_end = 1'b1;
        if (hp_eff) begin
          job.data_f    = 1'b1;
          job.data_num  = next_num;
          job.data_word = {pending_byte, PAD_BYTE};
          job.tail_byte = {3'd0, next_num};
        end else begin
          job.tail_byte = {3'd0, pc_eff};
        end
        in_string_next    = 1'b0;
        have_pending_next = 1'b0;
        pending_byte_next = 8'd0;
        packet_count_next = 5'd0;
      end
      default: begin
      end
    endcase
  end

  assign q_push = accept && (job.start_f || job.data_f || job.tail_f);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_string    <= 1'b0;
      have_pending <= 1'b0;
      pending_byte <= 8'd0;
      packet_count <= 5'd0;
    end else if (accept) begin
      in_string    <= in_string_next;
      have_pending <= have_pending_next;
      pending_byte <= pending_byte_next;
      packet_count <= packet_count_next;
    end
  end

  `RFS_ASSERT(a_pending_in_string, have_pending |-> in_string, "pending byte outside a string")
  `RFS_ASSERT(a_count_idle_zero, !in_string |-> packet_count == 5'd0, "count set outside a string")

endmodule

// File: rtl/rfs_queue.sv
// short job queue between front end and frame builder
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfs_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rfs_pkg::rfs_job_t push_job,
  output logic              ready,
  input  logic              pop,
  output logic              head_valid,
  output rfs_pkg::rfs_job_t head_job
);
  import rfs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  rfs_job_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign ready      = count != FULL_CNT;
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  `RFS_ASSERT(a_no_push_full, push |-> ready, "push into full queue")

endmodule

// File: rtl/rfs_back.sv
// back end: expands jobs into frames and holds the output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [9:0]        station_id,
  input  logic              q_valid,
  input  rfs_pkg::rfs_job_t q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       frame_word,
  output logic [1:0]        frame_kind,
  output logic              last_of_run
);
  import rfs_pkg::*;

  rfs_job_t   cur;
  logic [2:0] mask;        // {tail, data, start} still to send
  logic [2:0] pick, mask_after;
  logic       slot_free, advance, load;
  logic [4:0] sel_num;
  logic [15:0] sel_data;
  rfs_kind_t  sel_kind;
  logic [30:0] body;

  assign slot_free = !out_valid || !out_stall;
  assign advance   = slot_free && (mask != 3'd0);

  always_comb begin
    sel_num  = 5'd0;
    sel_data = 16'd0;
    sel_kind = KIND_CMD;
    pick     = 3'd0;
    priority if (mask[0]) begin
      pick     = 3'b001;
      sel_data = {TYPE_START, PAD_BYTE};
      sel_kind = KIND_START;
    end else if (mask[1]) begin
      pick     = 3'b010;
      sel_num  = cur.data_num;
      sel_data = cur.data_word;
      sel_kind = KIND_DATA;
    end else if (mask[2]) begin
      pick     = 3'b100;
      sel_data = {(cur.tail_end ? TYPE_END : TYPE_CMD), cur.tail_byte};
      sel_kind = cur.tail_end ? KIND_END : KIND_CMD;
    end
  end

  assign mask_after = mask & ~pick;
  assign load  = q_valid && ((mask == 3'd0) || (advance && (mask_after == 3'd0)));
  assign q_pop = load;
  assign body  = {station_id, sel_num, sel_data};

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_job;
    end
    if (advance) begin
      frame_word  <= {body, ^body};
      frame_kind  <= sel_kind;
      last_of_run <= mask_after == 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mask      <= 3'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (slot_free) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        mask <= {q_job.tail_f, q_job.data_f, q_job.start_f};
      end else if (advance) begin
        mask <= mask_after;
      end
    end
  end

  `RFS_ASSERT(a_even_parity, out_valid |-> !(^frame_word), "frame parity odd")
  `RFS_ASSERT(a_run_continues, out_valid && !last_of_run |-> mask != 3'd0, "run cut short")

endmodule

// File: rtl/radio_frame_sequencer.sv
// top level of the radio frame sequencer
`timescale 1ns / 1ps
//
// channel   direction  handshake            payload
// in        request    in_valid / in_stall  req_type, char_byte
// out       frame      out_valid/out_stall  frame_word, frame_kind, last_of_run
// cfg       apb        psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// a request is classified in the cycle it is accepted and lands in a job queue
// the frame builder sends one frame per cycle while out_stall is low and a job
//   is queued; a request that causes no frame never enters the queue
// reset clears string state, queue and output valid; station id goes to 288
// in_stall rises only when the job queue is full; out_stall holds the frame
//
module radio_frame_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  char_byte,
  // frame channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] frame_word,
  output logic [1:0]  frame_kind,
  output logic        last_of_run,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rfs_pkg::*;

  logic [9:0] station_id;
  logic       cfg_write;

  logic       q_push, q_ready, q_pop, q_valid;
  rfs_job_t   push_job, head_job;

  // register index sits in paddr[2], byte offset bits are not decoded
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_STATION_ID);
  assign prdata    = (paddr[2] == REG_STATION_ID) ? {22'd0, station_id} : 32'd0;

  // the all-ones id is reserved, a write of it leaves the id alone
  always_ff @(posedge clk) begin
    if (rst) begin
      station_id <= STATION_ID_INIT;
    end else if (cfg_write && (pwdata[9:0] != ID_ALL_ONES)) begin
      station_id <= pwdata[9:0];
    end
  end

  // front end: string state and classification
  rfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .char_byte (char_byte),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // decouples request intake from frame output
  rfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // back end: frame assembly, parity and output register
  rfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .station_id  (station_id),
    .q_valid     (q_valid),
    .q_job       (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_word  (frame_word),
    .frame_kind  (frame_kind),
    .last_of_run (last_of_run)
  );

endmodule

// File: tb/radio_frame_sequencer_tb.sv
// self-checking testbench of the radio frame sequencer
`timescale 1ns / 1ps

module radio_frame_sequencer_tb;
  import rfs_pkg::*;

  // byte addresses on the configuration port
  localparam logic [2:0] ADDR_STATION_ID = 3'd0;
  localparam logic [2:0] ADDR_SPARE      = 3'd4;  // no register behind it

  localparam int IDLE_LIMIT    = 2000;  // cycles with no request or frame moving
  localparam int SETTLE_CYCLES = 12;    // a request still in flight after the last frame
  localparam int MAX_REPORTS   = 10;

  // one frame as it leaves the block
  typedef struct packed {
    logic [31:0] word;
    rfs_kind_t   kind;
    logic        last;
  } frame_t;

  // a frame typed in by hand that replaces the computed one
  typedef struct packed {
    logic   on;
    frame_t f;
  } pin_entry_t;

  // one row of the directed table
  typedef struct packed {
    rfs_req_t    req;
    logic [7:0]  ch;
    logic        pinned;
    logic [31:0] word;
    rfs_kind_t   kind;
  } stim_row_t;

  // directed requests, station id still at its reset value of 288
  localparam int N_DIRECTED = 18;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{REQ_CMD,  8'h00, 1'b1, 32'h4800_0201, KIND_CMD},  // lowest command byte
    '{REQ_CMD,  8'hFF, 1'b1, 32'h4800_03FF, KIND_CMD},  // highest command byte
    '{REQ_END,  8'h00, 1'b0, 32'h0,         KIND_CMD},  // end with no string open
    '{REQ_NONE, 8'hAA, 1'b0, 32'h0,         KIND_CMD},  // unused request code
    '{REQ_CHAR, 8'h00, 1'b0, 32'h0,         KIND_CMD},  // start frame, byte held
    '{REQ_CMD,  8'h5A, 1'b0, 32'h0,         KIND_CMD},  // command inside a string
    '{REQ_CHAR, 8'hFF, 1'b0, 32'h0,         KIND_CMD},  // completes packet 1
    '{REQ_CHAR, 8'h12, 1'b0, 32'h0,         KIND_CMD},  // held only, no frame
    '{REQ_END,  8'h77, 1'b0, 32'h0,         KIND_CMD},  // pads odd byte, count 2
    '{REQ_CHAR, 8'hA5, 1'b0, 32'h0,         KIND_CMD},
    '{REQ_END,  8'h00, 1'b0, 32'h0,         KIND_CMD},  // one padded packet
    '{REQ_CHAR, 8'h34, 1'b0, 32'h0,         KIND_CMD},
    '{REQ_CHAR, 8'h56, 1'b0, 32'h0,         KIND_CMD},
    '{REQ_END,  8'hFF, 1'b0, 32'h0,         KIND_CMD},  // even string, no padding
    '{REQ_NONE, 8'h55, 1'b0, 32'h0,         KIND_CMD},
    '{REQ_CMD,  8'h81, 1'b0, 32'h0,         KIND_CMD},
    '{REQ_CHAR, 8'h01, 1'b0, 32'h0,         KIND_CMD},
    '{REQ_END,  8'h00, 1'b0, 32'h0,         KIND_CMD}
  };

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type  = REQ_CMD;
  logic [7:0]  char_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] frame_word;
  logic [1:0]  frame_kind;
  logic        last_of_run;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = 3'd0;
  logic [31:0] pwdata    = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  radio_frame_sequencer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .char_byte   (char_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_word  (frame_word),
    .frame_kind  (frame_kind),
    .last_of_run (last_of_run),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // frames the block still owes, oldest first
  frame_t     frames_due [$];
  // hand-typed frames, one entry per request raised, in request order
  pin_entry_t pinned_q [$];

  // our own copy of the block's state
  logic [9:0] pred_station_id = STATION_ID_INIT;
  logic       str_open        = 1'b0;
  logic       pend_valid      = 1'b0;
  logic [7:0] pend_byte       = 8'h00;
  logic [4:0] pkt_count       = 5'd0;

  int mismatch_count = 0;
  int requests_sent  = 0;   // requests other than the unused code
  int send_idle_pct  = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int idle_cycles    = 0;

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // frame predictor
  // -------------------------------------------------------------------------

  // id, packet number, data, then even parity over the whole word
  function automatic logic [31:0] build_frame(logic [4:0] num, logic [15:0] data);
    logic [31:0] w;
    w = {pred_station_id, num, data, 1'b0};
    w[0] = ^w;
    return w;
  endfunction

  function automatic void queue_frame(logic [4:0] num, logic [15:0] data, rfs_kind_t kind);
    frame_t f;
    f.word = build_frame(num, data);
    f.kind = kind;
    f.last = 1'b0;
    frames_due.push_back(f);
  endfunction

  // data packet numbers run 1..31 and wrap back to 1
  function automatic logic [4:0] bump_packet();
    if (pkt_count < MAX_PACKET) begin
      pkt_count = pkt_count + 5'd1;
    end else begin
      pkt_count = 5'd1;
    end
    return pkt_count;
  endfunction

  // start frame goes out only if no string is open yet
  function automatic void open_string();
    if (!str_open) begin
      queue_frame(5'd0, {TYPE_START, PAD_BYTE}, KIND_START);
      str_open   = 1'b1;
      pend_valid = 1'b0;
      pend_byte  = 8'h00;
      pkt_count  = 5'd0;
    end
  endfunction

  // frames caused by one accepted request, the final one flagged
  function automatic void predict_request(rfs_req_t req, logic [7:0] ch);
    int first;
    first = frames_due.size();
    case (req)
      REQ_CMD: begin
        queue_frame(5'd0, {TYPE_CMD, ch}, KIND_CMD);
      end
      REQ_CHAR: begin
        open_string();
        if (pend_valid) begin
          queue_frame(bump_packet(), {pend_byte, ch}, KIND_DATA);
          pend_valid = 1'b0;
          pend_byte  = 8'h00;
        end else begin
          pend_byte  = ch;
          pend_valid = 1'b1;
        end
      end
      REQ_END: begin
        open_string();
        // an odd byte left over is flushed with zero padding
        if (pend_valid) begin
          queue_frame(bump_packet(), {pend_byte, PAD_BYTE}, KIND_DATA);
        end
        queue_frame(5'd0, {TYPE_END, 3'b000, pkt_count}, KIND_END);
        str_open   = 1'b0;
        pend_valid = 1'b0;
        pend_byte  = 8'h00;
        pkt_count  = 5'd0;
      end
      default: begin
        // unused request code: nothing sent, nothing changes
      end
    endcase
    if (frames_due.size() > first) begin
      frames_due[frames_due.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
    end
  endfunction

  // -------------------------------------------------------------------------
  // traffic check and watchdog, sampled at the rising edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : traffic_check
    frame_t     want;
    pin_entry_t pin;
    logic       moved;
    moved = 1'b0;
    if (!rst) begin
      // request accepted: work out the frames it owes
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        predict_request(rfs_req_t'(req_type), char_byte);
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.on && frames_due.size() != 0) begin
            frames_due[frames_due.size() - 1] = pin.f;
          end
        end
      end
      // frame accepted: compare with the oldest one owed
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (frames_due.size() == 0) begin
          flag_mismatch("frame with nothing owed", 32'h0, frame_word);
        end else begin
          want = frames_due.pop_front();
          if (frame_word !== want.word) begin
            flag_mismatch("frame_word", want.word, frame_word);
          end
          if (frame_kind !== want.kind) begin
            flag_mismatch("frame_kind", 32'(want.kind), 32'(frame_kind));
          end
          if (last_of_run !== want.last) begin
            flag_mismatch("last_of_run", 32'(want.last), 32'(last_of_run));
          end
        end
      end
    end
    // watchdog: too long with neither channel moving
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired at %0t with %0d frames owed", $time, frames_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver back-pressure, drawn fresh at each falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // -------------------------------------------------------------------------
  // request side
  // -------------------------------------------------------------------------

  // raise one request after a random gap and hold it until accepted
  task automatic send_request(rfs_req_t req, logic [7:0] ch, pin_entry_t pin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pinned_q.push_back(pin);
    in_valid  <= 1'b1;
    req_type  <= req;
    char_byte <= ch;
    if (req != REQ_NONE) begin
      requests_sent++;
    end
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic send_random(rfs_req_t req);
    send_request(req, 8'($urandom_range(255)), '0);
  endtask

  // sender goes quiet until every owed frame has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // configuration port
  // -------------------------------------------------------------------------

  task automatic check_station_id();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_STATION_ID;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (prdata[9:0] !== pred_station_id) begin
      flag_mismatch("station_id read", 32'(pred_station_id), prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write, then read the station id back
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    // all-ones id and the spare address leave the register alone
    if (addr == ADDR_STATION_ID && data[9:0] != ID_ALL_ONES) begin
      pred_station_id = data[9:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_station_id();
  endtask

  // -------------------------------------------------------------------------
  // random phase: mostly whole strings with random content
  // -------------------------------------------------------------------------
  task automatic run_phase(int idle_pct, int stall_pct, int quota, bit force_wrap);
    int start;
    int pick;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = requests_sent;
    // long string so the packet number wraps from 31 back to 1
    if (force_wrap) begin
      repeat (66) send_random(REQ_CHAR);
      send_random(REQ_END);
    end
    while (requests_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        // whole string, now and then a long one, commands sprinkled inside
        len = ($urandom_range(49) == 0) ? $urandom_range(62, 70) : $urandom_range(0, 12);
        repeat (len) begin
          if ($urandom_range(9) == 0) begin
            send_random(REQ_CMD);
          end
          send_random(REQ_CHAR);
        end
        send_random(REQ_END);
      end else if (pick < 80) begin
        send_random(REQ_CMD);
      end else if (pick < 87) begin
        send_random(REQ_END);
      end else if (pick < 95) begin
        // string left open, the next string carries on from it
        repeat ($urandom_range(1, 5)) send_random(REQ_CHAR);
      end else begin
        send_random(REQ_NONE);
      end
    end
    settle();
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin : main_sequence
    pin_entry_t pin;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // station id out of reset
    check_station_id();

    // directed table, no idling on either side
    for (int i = 0; i < N_DIRECTED; i++) begin
      pin.on     = DIRECTED[i].pinned;
      pin.f.word = DIRECTED[i].word;
      pin.f.kind = DIRECTED[i].kind;
      pin.f.last = 1'b1;
      send_request(DIRECTED[i].req, DIRECTED[i].ch, pin);
    end
    settle();

    // lowest id, no idling
    write_reg(ADDR_STATION_ID, 32'd0);
    run_phase(0, 0, 62, 1'b1);

    // all-ones id and the spare address must both be ignored
    write_reg(ADDR_STATION_ID, 32'(ID_ALL_ONES));
    write_reg(ADDR_SPARE, 32'd5);

    // highest legal id, sender mostly idle
    write_reg(ADDR_STATION_ID, 32'd1022);
    run_phase(80, 0, 48, 1'b0);

    // upper data bits set, only the low ten count; receiver mostly stalled
    write_reg(ADDR_STATION_ID, 32'hFFFF_FC00 | 32'($urandom_range(1022)));
    run_phase(0, 80, 48, 1'b0);

    // both sides idle now and then
    write_reg(ADDR_STATION_ID, 32'($urandom_range(1022)));
    run_phase(19, 19, 48, 1'b0);

    if (mismatch_count == 0 && frames_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/rfs_pkg.sv
rtl/rfs_front.sv
rtl/rfs_queue.sv
rtl/rfs_back.sv
rtl/radio_frame_sequencer.sv
tb/radio_frame_sequencer_tb.sv
